// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define BSAT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsat assertion failed");

// Next-cycle implication, ignored while reset is high.
`define BSAT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsat assertion failed");

// Next-cycle implication that also holds across reset.
`define BSAT_ASSERT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bsat assertion failed");

`endif

// File: rtl/bsat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsat_pkg
// Types and constants shared by the byte shadow access tracker.
// ----------------------------------------------------------------------------
package bsat_pkg;

   // shadow store geometry
   localparam int SHADOW_AW    = 16;
   localparam int SHADOW_DEPTH = 1 << SHADOW_AW;
   localparam int MAX_BYTES    = 64;
   localparam int TID_BITS     = 16;
   localparam int EID_BITS     = 32;

   // port field widths
   localparam int REQ_TYPE_W  = 2;
   localparam int BYTE_ADDR_W = 16;
   localparam int BYTE_CNT_W  = 7;
   localparam int THREAD_W    = 16;
   localparam int EVENT_W     = 32;

   // internal widths
   localparam int CNT_W = $clog2(MAX_BYTES + 1);
   localparam int CMP_W = (CNT_W > BYTE_CNT_W) ? CNT_W : BYTE_CNT_W;
   localparam int SUM_W = ((SHADOW_AW > BYTE_ADDR_W) ? SHADOW_AW : BYTE_ADDR_W) + 1;

   // command queue, depth must be a power of two
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_RSVD  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_READ,
      CMD_QUERY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic                   qry_oor;
      logic [BYTE_ADDR_W-1:0] addr;
      logic [CNT_W-1:0]       count;
      logic [TID_BITS-1:0]    tid;
      logic [EID_BITS-1:0]    eid;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_QUERY,
      ST_RESP
   } state_type;

endpackage

// File: rtl/byte_shadow_access_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_shadow_access_tracker
// Per-byte shadow of last reader, last writer and write event id.
// ----------------------------------------------------------------------------
// Requests: drive req_* and raise start; the request transfers at a rising
// edge where start is high and busy is low. req_type selects a write access,
// a read access over req_byte_count bytes (clamped to 64), or a query of one
// byte. Every request yields exactly one result: rsp_valid is high for one
// cycle with rsp_status and the three shadow fields. The receiver cannot
// stall; results leave in request order.
// Reset: after reset is released the engine sweeps the 65536 shadow entries
// to all ones, one entry per cycle, and busy stays high until it is done.
// Sequence: the engine pops a transfer from a two-entry command queue in a
// dispatch state, then updates one byte per cycle for an access (one store
// port) or does a registered memory read for a query, and then raises the
// result in a result state. An empty or unused request, or an out of range
// query, goes straight from dispatch to the result. The queue lets the next
// request transfer while the current one executes; busy is high while two
// requests wait in it.
// ----------------------------------------------------------------------------
module byte_shadow_access_tracker import bsat_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic [BYTE_ADDR_W-1:0] req_byte_addr,
   input  logic [BYTE_CNT_W-1:0]  req_byte_count,
   input  logic [THREAD_W-1:0]    req_thread_id,
   input  logic [EVENT_W-1:0]     req_event_id,
   output logic                   rsp_valid,
   output logic                   rsp_status,
   output logic [THREAD_W-1:0]    rsp_reader_thread,
   output logic [THREAD_W-1:0]    rsp_writer_thread,
   output logic [EVENT_W-1:0]     rsp_writer_event
);

   cmd_type      push_cmd;
   cmd_type      head;
   q_status_type q_status;
   logic         push;
   logic         pop;
   logic         clearing;

   bsat_front u_front (
      .start          (start),
      .req_type       (req_type),
      .req_byte_addr  (req_byte_addr),
      .req_byte_count (req_byte_count),
      .req_thread_id  (req_thread_id),
      .req_event_id   (req_event_id),
      .q_status       (q_status),
      .clearing       (clearing),
      .busy           (busy),
      .push           (push),
      .cmd            (push_cmd)
   );

   bsat_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   bsat_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_reader_thread (rsp_reader_thread),
      .rsp_writer_thread (rsp_writer_thread),
      .rsp_writer_event  (rsp_writer_event)
   );

endmodule

// File: rtl/bsat_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsat_front
// Request intake: handshake, count clamp, type decode and query range check.
// ----------------------------------------------------------------------------
module bsat_front import bsat_pkg::*; (
   input  logic                   start,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic [BYTE_ADDR_W-1:0] req_byte_addr,
   input  logic [BYTE_CNT_W-1:0]  req_byte_count,
   input  logic [THREAD_W-1:0]    req_thread_id,
   input  logic [EVENT_W-1:0]     req_event_id,
   input  q_status_type           q_status,
   input  logic                   clearing,
   output logic                   busy,
   output logic                   push,
   output cmd_type                cmd
);

   logic [CMP_W-1:0] cnt_ext;
   logic [CNT_W-1:0] cnt_clamped;
   req_code_type     code;

   assign busy = clearing | q_status.full;
   assign push = start & ~busy;

   always_comb begin
      cnt_ext = CMP_W'(req_byte_count);
      if (cnt_ext > CMP_W'(MAX_BYTES)) begin
         cnt_clamped = CNT_W'(MAX_BYTES);
      end else begin
         cnt_clamped = CNT_W'(cnt_ext);
      end
   end

   always_comb begin
      code        = req_code_type'(req_type);
      cmd.addr    = req_byte_addr;
      cmd.count   = cnt_clamped;
      cmd.tid     = TID_BITS'(req_thread_id);
      cmd.eid     = EID_BITS'(req_event_id);
      cmd.qry_oor = 1'b0;
      unique case (code)
         REQ_WRITE: begin
            cmd.kind = (cnt_clamped != '0) ? CMD_WRITE : CMD_NONE;
         end
         REQ_READ: begin
            cmd.kind = (cnt_clamped != '0) ? CMD_READ : CMD_NONE;
         end
         REQ_QUERY: begin
            cmd.kind    = CMD_QUERY;
            cmd.qry_oor = ((SUM_W'(req_byte_addr) >> SHADOW_AW) != '0);
         end
         default: begin
            cmd.kind = CMD_NONE;
         end
      endcase
   end

endmodule

// File: rtl/bsat_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsat_queue
// Short command FIFO between the intake and the execution engine.
// ----------------------------------------------------------------------------
module bsat_queue import bsat_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type q_status
);

   cmd_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign head           = slot_ff[rd_ptr_ff];
   assign q_status.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_status.empty = (cnt_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/bsat_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsat_back
// Execution engine: shadow stores, clearing pass, per-byte update loop and
// query read, plus the result strobe.
// ----------------------------------------------------------------------------
module bsat_back import bsat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               head,
   input  q_status_type          q_status,
   output logic                  pop,
   output logic                  clearing,
   output logic                  rsp_valid,
   output logic                  rsp_status,
   output logic [THREAD_W-1:0]   rsp_reader_thread,
   output logic [THREAD_W-1:0]   rsp_writer_thread,
   output logic [EVENT_W-1:0]    rsp_writer_event
);

   logic [TID_BITS-1:0] reader_mem [SHADOW_DEPTH];
   logic [TID_BITS-1:0] writer_mem [SHADOW_DEPTH];
   logic [EID_BITS-1:0] event_mem  [SHADOW_DEPTH];

   logic [TID_BITS-1:0] reader_q_ff;
   logic [TID_BITS-1:0] writer_q_ff;
   logic [EID_BITS-1:0] event_q_ff;

   state_type            state_ff, state_in;
   logic [SHADOW_AW-1:0] clr_idx_ff;
   cmd_type              cmd_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic                 status_ff;

   logic [SUM_W-1:0]     byte_sum;
   logic                 byte_oor;
   logic                 last_byte;
   logic                 clr_last;

   // memory port controls
   logic                 we_rd, we_wr, re;
   logic [SHADOW_AW-1:0] mem_addr;
   logic [TID_BITS-1:0]  rd_wdata, wr_wdata;
   logic [EID_BITS-1:0]  ev_wdata;

   assign byte_sum  = SUM_W'(cmd_ff.addr) + SUM_W'(idx_ff);
   assign byte_oor  = ((byte_sum >> SHADOW_AW) != '0);
   assign last_byte = ((idx_ff + 1'b1) == cmd_ff.count);
   assign clr_last  = (clr_idx_ff == '1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               unique case (head.kind)
                  CMD_WRITE, CMD_READ: state_in = ST_ACCESS;
                  CMD_QUERY:           state_in = head.qry_oor ? ST_RESP : ST_QUERY;
                  default:             state_in = ST_RESP;
               endcase
            end
         end
         ST_ACCESS: begin
            if (last_byte) state_in = ST_RESP;
         end
         ST_QUERY: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      we_rd     = 1'b0;
      we_wr     = 1'b0;
      re        = 1'b0;
      pop       = 1'b0;
      clearing  = 1'b0;
      rsp_valid = 1'b0;
      mem_addr  = byte_sum[SHADOW_AW-1:0];
      rd_wdata  = '1;
      wr_wdata  = cmd_ff.tid;
      ev_wdata  = cmd_ff.eid;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            we_rd    = 1'b1;
            we_wr    = 1'b1;
            mem_addr = clr_idx_ff;
            wr_wdata = '1;
            ev_wdata = '1;
         end
         ST_IDLE: begin
            pop = ~q_status.empty;
         end
         ST_ACCESS: begin
            if (!byte_oor) begin
               if (cmd_ff.kind == CMD_WRITE) begin
                  we_rd = 1'b1;
                  we_wr = 1'b1;
               end else begin
                  we_rd    = 1'b1;
                  rd_wdata = cmd_ff.tid;
               end
            end
         end
         ST_QUERY: begin
            re       = 1'b1;
            mem_addr = cmd_ff.addr[SHADOW_AW-1:0];
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff    <= head;
         idx_ff    <= '0;
         status_ff <= head.qry_oor;
      end else if (state_ff == ST_ACCESS) begin
         idx_ff <= idx_ff + 1'b1;
         if (byte_oor) status_ff <= 1'b1;
      end
   end

   // shadow stores, one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (we_rd) reader_mem[mem_addr] <= rd_wdata;
      if (re)    reader_q_ff <= reader_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (we_wr) writer_mem[mem_addr] <= wr_wdata;
      if (re)    writer_q_ff <= writer_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (we_wr) event_mem[mem_addr] <= ev_wdata;
      if (re)    event_q_ff <= event_mem[mem_addr];
   end

   // accesses report zeros, an out of range query reports all ones
   always_comb begin
      rsp_status = status_ff;
      if (cmd_ff.kind == CMD_QUERY && !cmd_ff.qry_oor) begin
         rsp_reader_thread = THREAD_W'(reader_q_ff);
         rsp_writer_thread = THREAD_W'(writer_q_ff);
         rsp_writer_event  = EVENT_W'(event_q_ff);
      end else if (cmd_ff.qry_oor) begin
         rsp_reader_thread = '1;
         rsp_writer_thread = '1;
         rsp_writer_event  = '1;
      end else begin
         rsp_reader_thread = '0;
         rsp_writer_thread = '0;
         rsp_writer_event  = '0;
      end
   end

endmodule

// File: rtl/bsat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsat_checker
// Port-level checks on the tracker's result channel and reset behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsat_checker import bsat_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic                   rsp_status,
   input logic [THREAD_W-1:0]    rsp_reader_thread,
   input logic [THREAD_W-1:0]    rsp_writer_thread,
   input logic [EVENT_W-1:0]     rsp_writer_event
);

   logic all_ones;
   logic all_zero;

   assign all_ones = (rsp_reader_thread == '1) && (rsp_writer_thread == '1)
                     && (rsp_writer_event == '1);
   assign all_zero = (rsp_reader_thread == '0) && (rsp_writer_thread == '0)
                     && (rsp_writer_event == '0);

   // store sweep starts right out of reset
   `BSAT_ASSERT_RST(a_reset_busy, clock, reset, busy && !rsp_valid)

   // a result occupies one cycle, then the engine redispatches
   `BSAT_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)

   // flagged results are either an access (zeros) or a bad query (ones)
   `BSAT_ASSERT_IMP(a_oor_fields, clock, reset, rsp_valid && rsp_status, all_ones || all_zero)

endmodule

bind byte_shadow_access_tracker bsat_checker u_bsat_checker (.*);
